FILE: src/avcc_record_to_annexb_defines.svh
// assertion macros used by the checker file
// no dependencies; clk_i and rst_ni must be visible where the macros are used
`ifndef AVCC_RECORD_TO_ANNEXB_DEFINES_SVH
`define AVCC_RECORD_TO_ANNEXB_DEFINES_SVH

// clocked property body with reset disable
`define A2AB_PROP(p) @(posedge clk_i) disable iff (!rst_ni) (p)

// labeled assertion with error report
`define A2AB_ASSERT(lbl, p, msg) \
  lbl: assert property (`A2AB_PROP(p)) else $error(msg);

`endif

FILE: src/a2ab_pkg.sv
// shared types and constants for the avcc record to annex b converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package a2ab_pkg;

  localparam logic [7:0] AvccVersion = 8'd1;
  localparam logic [2:0] HeaderLastPos = 3'd5;
  localparam logic [7:0] SpsCountMask = 8'h1F;
  localparam logic [7:0] StartCodeLast = 8'h01;
  localparam logic [2:0] StartCodeLen = 3'd4;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_PPS_COUNT
  } phase_e;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_DONE  = 2'd1,
    ST_BAD   = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  // results caused by one input byte: optional start code, optional data
  // byte, optional trailing status result
  typedef struct packed {
    logic       sc;
    logic       dat;
    status_e    st;
    logic [7:0] data_byte;
    logic       kind;
    logic [7:0] idx;
    logic       uend;
  } burst_t;

endpackage

`default_nettype wire

FILE: src/a2ab_in_if.sv
// input byte channel: valid/ready with record byte and last flag
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface a2ab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

FILE: src/a2ab_out_if.sv
// result channel: valid/ready with annex b byte and tags
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface a2ab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       set_kind;
  logic [7:0] set_index;
  logic       unit_end;
  logic [1:0] status;
  logic       run_last;

  modport source (
    output valid, output out_byte, output set_kind, output set_index,
    output unit_end, output status, output run_last, input ready
  );
  modport sink (
    input valid, input out_byte, input set_kind, input set_index,
    input unit_end, input status, input run_last, output ready
  );
endinterface

`default_nettype wire

FILE: src/a2ab_parse.sv
// record parser: walks the avcc record state per accepted byte and
// describes the results that byte causes; uses a2ab_pkg
`timescale 1ns / 1ps
`default_nettype none

module a2ab_parse (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            in_last_i,
  output a2ab_pkg::burst_t     burst_o
);

  a2ab_pkg::phase_e phase_q, phase_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [7:0]  sets_q, sets_d;
  logic        kind_q, kind_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  lhi_q, lhi_d;
  logic [15:0] left_q, left_d;
  logic        fin_q, fin_d;
  logic        do_next;
  logic        do_unit;
  logic [15:0] len_w;

  always_comb begin
    phase_d = phase_q;
    hpos_d  = hpos_q;
    sets_d  = sets_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    lhi_d   = lhi_q;
    left_d  = left_q;
    fin_d   = fin_q;
    do_next = 1'b0;
    do_unit = 1'b0;
    len_w   = {lhi_q, in_byte_i};

    burst_o           = '0;
    burst_o.st        = a2ab_pkg::ST_DATA;
    burst_o.data_byte = in_byte_i;
    burst_o.kind      = kind_q;
    burst_o.idx       = idx_q;

    if (!fin_q) begin
      case (phase_q)
        a2ab_pkg::PH_HEADER: begin
          if (hpos_q == 3'd0 && in_byte_i != a2ab_pkg::AvccVersion) begin
            fin_d      = 1'b1;
            burst_o.st = a2ab_pkg::ST_BAD;
          end else if (hpos_q == a2ab_pkg::HeaderLastPos) begin
            sets_d  = in_byte_i & a2ab_pkg::SpsCountMask;
            kind_d  = 1'b0;
            idx_d   = 8'd0;
            do_next = 1'b1;
          end else begin
            hpos_d = hpos_q + 3'd1;
          end
        end
        a2ab_pkg::PH_LEN_HI: begin
          lhi_d   = in_byte_i;
          phase_d = a2ab_pkg::PH_LEN_LO;
        end
        a2ab_pkg::PH_LEN_LO: begin
          left_d       = len_w;
          burst_o.sc   = 1'b1;
          burst_o.uend = (len_w == 16'd0);
          if (len_w == 16'd0) begin
            do_unit = 1'b1;
          end else begin
            phase_d = a2ab_pkg::PH_DATA;
          end
        end
        a2ab_pkg::PH_DATA: begin
          left_d       = left_q - 16'd1;
          burst_o.dat  = 1'b1;
          burst_o.uend = (left_q == 16'd1);
          do_unit      = (left_q == 16'd1);
        end
        a2ab_pkg::PH_PPS_COUNT: begin
          sets_d  = in_byte_i;
          kind_d  = 1'b1;
          idx_d   = 8'd0;
          do_next = 1'b1;
        end
        default: begin
          phase_d = a2ab_pkg::PH_HEADER;
        end
      endcase
    end

    if (do_unit) begin
      sets_d  = sets_q - 8'd1;
      idx_d   = idx_q + 8'd1;
      do_next = 1'b1;
    end

    if (do_next) begin
      if (sets_d != 8'd0) begin
        phase_d = a2ab_pkg::PH_LEN_HI;
      end else if (!kind_d) begin
        phase_d = a2ab_pkg::PH_PPS_COUNT;
      end else begin
        fin_d      = 1'b1;
        burst_o.st = a2ab_pkg::ST_DONE;
      end
    end

    if (in_last_i) begin
      if (!fin_d) begin
        burst_o.st = a2ab_pkg::ST_TRUNC;
      end
      phase_d = a2ab_pkg::PH_HEADER;
      hpos_d  = 3'd0;
      sets_d  = 8'd0;
      kind_d  = 1'b0;
      idx_d   = 8'd0;
      lhi_d   = 8'd0;
      left_d  = 16'd0;
      fin_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= a2ab_pkg::PH_HEADER;
      hpos_q  <= 3'd0;
      sets_q  <= 8'd0;
      kind_q  <= 1'b0;
      idx_q   <= 8'd0;
      lhi_q   <= 8'd0;
      left_q  <= 16'd0;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      sets_q  <= sets_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
      lhi_q   <= lhi_d;
      left_q  <= left_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/avcc_record_to_annexb.sv
// avcc record to annex b converter, top level; uses a2ab_pkg,
// a2ab_in_if, a2ab_out_if and a2ab_parse
// A record byte is taken in every cycle while the second queue entry is
// free, which holds while the result side keeps up with single-result
// bytes; a length-low byte produces the four-byte start code burst, plus a
// status result when one follows. The parser updates its state in the cycle
// the byte is taken and hands a burst descriptor to a two-entry result queue,
// so one further result-causing byte is accepted while a burst is still
// draining. run_last marks the last result of each byte; status results
// carry zero data fields.
`timescale 1ns / 1ps
`default_nettype none

module avcc_record_to_annexb (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  a2ab_in_if.sink      in_i,
  a2ab_out_if.source   out_o
);

  a2ab_pkg::burst_t burst;
  a2ab_pkg::burst_t head_q, head_d, spare_q, spare_d;
  logic       head_vld_q, head_vld_d, spare_vld_q, spare_vld_d;
  logic [2:0] pos_q, pos_d;
  logic       accept;
  logic       push;
  logic       out_fire;
  logic       pop;
  logic [2:0] n_res;
  logic       in_sc;
  logic       in_dat;
  logic       is_status;

  assign in_i.ready = !spare_vld_q;
  assign accept     = in_i.valid && !spare_vld_q;

  a2ab_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .in_last_i (in_i.in_last),
    .burst_o   (burst)
  );

  assign push = accept && (burst.sc || burst.dat || burst.st != a2ab_pkg::ST_DATA);

  // output sequencing within the head burst
  always_comb begin
    n_res = (head_q.sc ? a2ab_pkg::StartCodeLen : 3'd0)
          + {2'd0, head_q.dat}
          + {2'd0, head_q.st != a2ab_pkg::ST_DATA};
    in_sc     = head_q.sc && (pos_q < a2ab_pkg::StartCodeLen);
    in_dat    = head_q.dat && (pos_q == 3'd0);
    is_status = !in_sc && !in_dat;

    out_o.valid    = head_vld_q;
    out_o.run_last = (pos_q == n_res - 3'd1);
    out_o.out_byte = 8'd0;
    out_o.unit_end = 1'b0;
    out_o.status   = a2ab_pkg::ST_DATA;
    out_o.set_kind = 1'b0;
    out_o.set_index = 8'd0;
    if (in_sc) begin
      out_o.out_byte = (pos_q == a2ab_pkg::StartCodeLen - 3'd1)
                     ? a2ab_pkg::StartCodeLast : 8'd0;
      out_o.unit_end = head_q.uend && (pos_q == a2ab_pkg::StartCodeLen - 3'd1);
    end else if (in_dat) begin
      out_o.out_byte = head_q.data_byte;
      out_o.unit_end = head_q.uend;
    end
    if (is_status) begin
      out_o.status = head_q.st;
    end else begin
      out_o.set_kind  = head_q.kind;
      out_o.set_index = head_q.idx;
    end
  end

  assign out_fire = head_vld_q && out_o.ready;
  assign pop      = out_fire && out_o.run_last;

  // two-entry burst queue
  always_comb begin
    head_d      = head_q;
    head_vld_d  = head_vld_q;
    spare_d     = spare_q;
    spare_vld_d = spare_vld_q;
    pos_d       = pos_q;
    if (pop) begin
      pos_d = 3'd0;
      if (spare_vld_q) begin
        head_d      = spare_q;
        spare_vld_d = push;
        spare_d     = burst;
      end else begin
        head_vld_d = push;
        head_d     = burst;
      end
    end else begin
      if (out_fire) begin
        pos_d = pos_q + 3'd1;
      end
      if (push) begin
        if (!head_vld_q) begin
          head_vld_d = 1'b1;
          head_d     = burst;
        end else begin
          spare_vld_d = 1'b1;
          spare_d     = burst;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= 1'b0;
      spare_vld_q <= 1'b0;
      pos_q       <= 3'd0;
    end else begin
      head_vld_q  <= head_vld_d;
      spare_vld_q <= spare_vld_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

endmodule

`default_nettype wire

FILE: src/a2ab_checker.sv
// port-level checks on the converter output, bound to the top level
// uses avcc_record_to_annexb_defines.svh and a2ab_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "avcc_record_to_annexb_defines.svh"

module a2ab_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       set_kind_i,
  input wire logic [7:0] set_index_i,
  input wire logic       unit_end_i,
  input wire logic [1:0] status_i,
  input wire logic       run_last_i
);

  `A2AB_ASSERT(a_status_ends_run, out_valid_i && status_i != a2ab_pkg::ST_DATA |-> run_last_i, "status result not last of its run")
  `A2AB_ASSERT(a_status_zero_fields, out_valid_i && status_i != a2ab_pkg::ST_DATA |-> out_byte_i == 8'd0 && set_index_i == 8'd0 && !set_kind_i && !unit_end_i, "status result with data fields")
  `A2AB_ASSERT(a_unit_end_on_data, out_valid_i && unit_end_i |-> status_i == a2ab_pkg::ST_DATA, "unit end on status result")
  `A2AB_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(status_i) && $stable(run_last_i), "stalled result changed")

endmodule

bind avcc_record_to_annexb a2ab_checker u_a2ab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .set_kind_i  (out_o.set_kind),
  .set_index_i (out_o.set_index),
  .unit_end_i  (out_o.unit_end),
  .status_i    (out_o.status),
  .run_last_i  (out_o.run_last)
);

`default_nettype wire

FILE: sim/tb.sv
// testbench for avcc_record_to_annexb: directed record table, then random records under
// four idle and stall mixes, results checked against the table or an in-bench predictor
// depends on a2ab_pkg, a2ab_in_if, a2ab_out_if and avcc_record_to_annexb
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 32;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 30;
  localparam int IdlePct [4] = '{0, 79, 0, 32};
  localparam int StallPct [4] = '{0, 0, 79, 32};

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                set_kind;
    logic [7:0]          set_index;
    logic                unit_end;
    a2ab_pkg::status_e   status;
    logic                run_last;
  } annexb_res_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } rec_item_t;

  typedef struct packed {
    logic [7:0]          val;
    logic                last;
    logic                typed;
    a2ab_pkg::status_e   status;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  a2ab_in_if in_if ();
  a2ab_out_if out_if ();

  avcc_record_to_annexb i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // converter state mirror
  a2ab_pkg::phase_e ph_r;
  logic [2:0]  hdr_pos_r;
  logic [7:0]  sets_left_r;
  logic        kind_r;
  logic [7:0]  index_r;
  logic [7:0]  len_hi_r;
  logic [15:0] bytes_left_r;
  logic        done_r;

  annexb_res_t step_q[$];
  annexb_res_t annexb_q[$];
  rec_item_t   rec_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int err_cnt = 0;
  int res_cnt = 0;
  int cyc_cnt = 0;

  dir_row_t dir_tbl [25] = '{
    // bad version, then an ignored byte that ends the record, then a one-byte bad record
    '{8'h00, 1'b0, 1'b1, a2ab_pkg::ST_BAD},
    '{8'hAA, 1'b1, 1'b0, a2ab_pkg::ST_DATA},
    '{8'hFF, 1'b1, 1'b1, a2ab_pkg::ST_BAD},
    // record cut on its first byte
    '{8'h01, 1'b1, 1'b1, a2ab_pkg::ST_TRUNC},
    // one two-byte sequence set, one empty picture set, trailing byte
    '{8'h01, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h64, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h1F, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'hFF, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'hE1, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h02, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h67, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'hAA, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h01, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'hFF, 1'b1, 1'b0, a2ab_pkg::ST_DATA},
    // no sets of either kind
    '{8'h01, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'hE0, 1'b0, 1'b0, a2ab_pkg::ST_DATA},
    '{8'h00, 1'b1, 1'b1, a2ab_pkg::ST_DONE}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CycleLimit) begin
      $display("avcc_record_to_annexb: mismatch");
      $finish;
    end
  end

  task automatic report_err(input string msg);
    err_cnt++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic void clear_state();
    ph_r = a2ab_pkg::PH_HEADER;
    hdr_pos_r = '0;
    sets_left_r = '0;
    kind_r = 1'b0;
    index_r = '0;
    len_hi_r = '0;
    bytes_left_r = '0;
    done_r = 1'b0;
  endfunction

  function automatic void put_status(input a2ab_pkg::status_e st);
    step_q.push_back('{out_byte: 8'h00, set_kind: 1'b0, set_index: 8'h00,
                       unit_end: 1'b0, status: st, run_last: 1'b0});
  endfunction

  function automatic void put_data(input logic [7:0] ob, input logic ue);
    step_q.push_back('{out_byte: ob, set_kind: kind_r, set_index: index_r,
                       unit_end: ue, status: a2ab_pkg::ST_DATA, run_last: 1'b0});
  endfunction

  function automatic void next_set();
    if (sets_left_r != 0) begin
      ph_r = a2ab_pkg::PH_LEN_HI;
    end else if (kind_r == 1'b0) begin
      ph_r = a2ab_pkg::PH_PPS_COUNT;
    end else begin
      done_r = 1'b1;
      put_status(a2ab_pkg::ST_DONE);
    end
  endfunction

  function automatic void unit_done();
    sets_left_r = sets_left_r - 8'd1;
    index_r = index_r + 8'd1;
    next_set();
  endfunction

  function automatic void annexb_predict(input logic [7:0] val, input logic last);
    step_q.delete();
    if (!done_r) begin
      case (ph_r)
        a2ab_pkg::PH_HEADER: begin
          if (hdr_pos_r == 0 && val != a2ab_pkg::AvccVersion) begin
            done_r = 1'b1;
            put_status(a2ab_pkg::ST_BAD);
          end else if (hdr_pos_r == a2ab_pkg::HeaderLastPos) begin
            sets_left_r = val & a2ab_pkg::SpsCountMask;
            kind_r = 1'b0;
            index_r = '0;
            next_set();
          end else begin
            hdr_pos_r = hdr_pos_r + 3'd1;
          end
        end
        a2ab_pkg::PH_LEN_HI: begin
          len_hi_r = val;
          ph_r = a2ab_pkg::PH_LEN_LO;
        end
        a2ab_pkg::PH_LEN_LO: begin
          bytes_left_r = {len_hi_r, val};
          for (int k = 0; k < a2ab_pkg::StartCodeLen; k++) begin
            put_data((k == 3) ? a2ab_pkg::StartCodeLast : 8'h00,
                     (k == 3) && (bytes_left_r == 0));
          end
          if (bytes_left_r == 0) unit_done();
          else ph_r = a2ab_pkg::PH_DATA;
        end
        a2ab_pkg::PH_DATA: begin
          bytes_left_r = bytes_left_r - 16'd1;
          put_data(val, bytes_left_r == 0);
          if (bytes_left_r == 0) unit_done();
        end
        a2ab_pkg::PH_PPS_COUNT: begin
          sets_left_r = val;
          kind_r = 1'b1;
          index_r = '0;
          next_set();
        end
        default: begin
          ph_r = a2ab_pkg::PH_HEADER;
        end
      endcase
    end
    if (last) begin
      if (!done_r) put_status(a2ab_pkg::ST_TRUNC);
      clear_state();
    end
    if (step_q.size() > 0) step_q[$].run_last = 1'b1;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] val, input logic last, input logic typed,
                           input a2ab_pkg::status_e st);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= val;
    in_if.in_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    annexb_predict(val, last);
    if (typed) begin
      annexb_q.push_back('{out_byte: 8'h00, set_kind: 1'b0, set_index: 8'h00,
                           unit_end: 1'b0, status: st, run_last: 1'b1});
    end else begin
      foreach (step_q[k]) annexb_q.push_back(step_q[k]);
    end
    @(negedge clk_i);
  endtask

  task automatic add_sets(input int count, input bit big_first);
    int len;
    for (int s = 0; s < count; s++) begin
      len = (big_first && s == 0) ? 256 + $urandom_range(0, 7) : $urandom_range(0, 6);
      rec_q.push_back('{val: 8'(len >> 8), last: 1'b0});
      rec_q.push_back('{val: 8'(len), last: 1'b0});
      repeat (len) rec_q.push_back('{val: 8'($urandom), last: 1'b0});
    end
  endtask

  task automatic gen_record(input bit want_big);
    int n_sps;
    int cut;
    rec_q.delete();
    if (!want_big && $urandom_range(99) < 6) begin
      rec_q.push_back('{val: ($urandom_range(1) ? 8'h00 : 8'($urandom_range(2, 255))),
                        last: 1'b0});
      repeat ($urandom_range(0, 3)) rec_q.push_back('{val: 8'($urandom), last: 1'b0});
    end else begin
      rec_q.push_back('{val: a2ab_pkg::AvccVersion, last: 1'b0});
      repeat (4) rec_q.push_back('{val: 8'($urandom), last: 1'b0});
      n_sps = want_big ? $urandom_range(1, 3) : $urandom_range(0, 3);
      rec_q.push_back('{val: {3'($urandom), 5'(n_sps)}, last: 1'b0});
      add_sets(n_sps, want_big);
      n_sps = $urandom_range(0, 3);
      rec_q.push_back('{val: 8'(n_sps), last: 1'b0});
      add_sets(n_sps, 1'b0);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) rec_q.push_back('{val: 8'($urandom), last: 1'b0});
      end
      // cut short to exercise the truncated status
      if (!want_big && $urandom_range(99) < 15) begin
        cut = $urandom_range(1, rec_q.size());
        while (rec_q.size() > cut) void'(rec_q.pop_back());
      end
    end
    rec_q[$].last = 1'b1;
  endtask

  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_left = HoldCycles;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    annexb_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (annexb_q.size() == 0) begin
        report_err($sformatf("result %0d unexpected: byte %02h status %0d",
                             res_cnt, out_if.out_byte, out_if.status));
      end else begin
        want = annexb_q.pop_front();
        if (out_if.out_byte !== want.out_byte || out_if.set_kind !== want.set_kind ||
            out_if.set_index !== want.set_index || out_if.unit_end !== want.unit_end ||
            out_if.status !== want.status || out_if.run_last !== want.run_last) begin
          report_err($sformatf(
            "result %0d: got %02h/%0d/%0d/%0d/%0d/%0d want %02h/%0d/%0d/%0d/%0d/%0d",
            res_cnt, out_if.out_byte, out_if.set_kind, out_if.set_index, out_if.unit_end,
            out_if.status, out_if.run_last, want.out_byte, want.set_kind, want.set_index,
            want.unit_end, want.status, want.run_last));
        end
      end
      res_cnt++;
    end
  end

  initial begin
    int sent;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    clear_state();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[k]) begin
      send_byte(dir_tbl[k].val, dir_tbl[k].last, dir_tbl[k].typed, dir_tbl[k].status);
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct = IdlePct[p];
      stall_pct = StallPct[p];
      // long receiver hold while a large set streams in
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        gen_record(p == 0 && sent == 0);
        foreach (rec_q[k]) send_byte(rec_q[k].val, rec_q[k].last, 1'b0, a2ab_pkg::ST_DATA);
        sent += rec_q.size();
      end
    end
    in_if.valid <= 1'b0;

    while (annexb_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (annexb_q.size() != 0) begin
      report_err($sformatf("%0d results never arrived", annexb_q.size()));
    end
    if (err_cnt == 0) begin
      $display("avcc_record_to_annexb: match");
    end else begin
      $display("avcc_record_to_annexb: mismatch");
    end
    $finish;
  end

endmodule
